[hdl/roiae_pkg.sv]
package roiae_pkg;

    localparam int COORD_BITS    = 11;
    localparam int PIXEL_BITS    = 8;
    localparam int EXPOSURE_BITS = 16;

    localparam int ROI_BITS   = COORD_BITS + 1;
    localparam int AREA_BITS  = 2 * ROI_BITS;
    localparam int SUM_BITS   = 30;
    localparam int COUNT_BITS = 23;
    localparam int TGT_BITS   = 8;
    localparam int WANT_BITS  = PIXEL_BITS + 2;
    localparam int PROD_BITS  = WANT_BITS - 1 + EXPOSURE_BITS;

    localparam int NUM_BITS = (SUM_BITS > PROD_BITS) ? SUM_BITS : PROD_BITS;
    localparam int DEN_A    = (COUNT_BITS > AREA_BITS) ? COUNT_BITS : AREA_BITS;
    localparam int DEN_BITS = (DEN_A > PIXEL_BITS) ? DEN_A : PIXEL_BITS;
    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    localparam int ADDR_BITS = 5;
    localparam int DATA_BITS = 32;

    localparam logic [TGT_BITS-1:0]      TARGET_RESET = TGT_BITS'(120);
    localparam logic [EXPOSURE_BITS-1:0] FLOOR_RESET  = '0;
    localparam logic [EXPOSURE_BITS-1:0] CEIL_RESET   = '1;
    localparam logic [1:0]               PHASE_LAST   = 2'd3;
    localparam logic [1:0]               PHASE_UPDATE = 2'd2;

    typedef enum logic [2:0] {
        REG_ENABLE,
        REG_LEFT,
        REG_TOP,
        REG_COLS,
        REG_ROWS,
        REG_TARGET,
        REG_FLOOR,
        REG_CEIL
    } reg_idx_t;

    typedef enum logic [1:0] {
        SRC_FRAME,
        SRC_REGION,
        SRC_EXPOSURE
    } div_src_t;

    typedef enum logic [2:0] {
        CAP_NONE,
        CAP_AREA,
        CAP_FA,
        CAP_RA,
        CAP_PROD,
        CAP_DONE
    } capture_t;

    typedef struct packed {
        logic     div_load;
        div_src_t div_src;
        logic     div_wait;
        capture_t capture;
        logic     last;
    } ucode_t;

    localparam int STEP_BITS = 4;

    localparam logic [STEP_BITS-1:0] STEP_IDLE     = 4'd0;
    localparam logic [STEP_BITS-1:0] STEP_AREA     = 4'd1;
    localparam logic [STEP_BITS-1:0] STEP_DIV_FA   = 4'd2;
    localparam logic [STEP_BITS-1:0] STEP_FA       = 4'd3;
    localparam logic [STEP_BITS-1:0] STEP_DIV_RA   = 4'd4;
    localparam logic [STEP_BITS-1:0] STEP_RA       = 4'd5;
    localparam logic [STEP_BITS-1:0] STEP_PROD     = 4'd6;
    localparam logic [STEP_BITS-1:0] STEP_LOAD_EXP = 4'd7;
    localparam logic [STEP_BITS-1:0] STEP_DIV_EXP  = 4'd8;
    localparam logic [STEP_BITS-1:0] STEP_DONE     = 4'd9;

    // control store
    function automatic ucode_t ucode_rom(input logic [STEP_BITS-1:0] step);
        ucode_t uc;
        uc = '{div_load: 1'b0, div_src: SRC_FRAME, div_wait: 1'b0,
               capture: CAP_NONE, last: 1'b0};
        case (step)
            STEP_IDLE: ;
            STEP_AREA:
            begin
                uc.capture  = CAP_AREA;
                uc.div_load = 1'b1;
                uc.div_src  = SRC_FRAME;
            end
            STEP_DIV_FA:   uc.div_wait = 1'b1;
            STEP_FA:
            begin
                uc.capture  = CAP_FA;
                uc.div_load = 1'b1;
                uc.div_src  = SRC_REGION;
            end
            STEP_DIV_RA:   uc.div_wait = 1'b1;
            STEP_RA:       uc.capture  = CAP_RA;
            STEP_PROD:     uc.capture  = CAP_PROD;
            STEP_LOAD_EXP:
            begin
                uc.div_load = 1'b1;
                uc.div_src  = SRC_EXPOSURE;
            end
            STEP_DIV_EXP:  uc.div_wait = 1'b1;
            STEP_DONE:
            begin
                uc.capture = CAP_DONE;
                uc.last    = 1'b1;
            end
            default:       uc.last = 1'b1;
        endcase
        return uc;
    endfunction

    function automatic logic [EXPOSURE_BITS-1:0] start_exposure(
        input logic [EXPOSURE_BITS-1:0] floor_v,
        input logic [EXPOSURE_BITS-1:0] ceil_v
    );
        logic [EXPOSURE_BITS-1:0] diff;
        diff = ceil_v - floor_v;
        if (floor_v > ceil_v)
            return '0;
        return diff >> 1;
    endfunction

endpackage

[hdl/roi_auto_exposure_update.sv]
// channel  | direction | handshake            | word
// ---------+-----------+----------------------+------------------------------------------
// in       | input     | in_valid / in_stall  | pixel, column, row, frame_end
// out      | output    | out_valid / out_stall| phase, new_exposure, frame_average,
//          |           |                      | roi_average, wanted_average, divide_fault
// apb      | input     | psel/penable/pready  | paddr, pwdata, prdata
//
// Pixels are taken one per cycle while in_stall is low; pattern-phase frame ends report
// in the next cycle. An update frame end runs the microcode: three 30-step restoring
// divisions plus six control steps, during which in_stall is high.
// in_stall is also high while a result waits in the output register under out_stall.
// Reset (rst_n low, async) clears sums, phase, registers to defaults; no clearing pass.
module roi_auto_exposure_update
    import roiae_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [PIXEL_BITS-1:0]    pixel,
    input  logic [COORD_BITS-1:0]    column,
    input  logic [COORD_BITS-1:0]    row,
    input  logic                     frame_end,

    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [1:0]               phase,
    output logic [EXPOSURE_BITS-1:0] new_exposure,
    output logic [PIXEL_BITS-1:0]    frame_average,
    output logic [PIXEL_BITS-1:0]    roi_average,
    output logic signed [WANT_BITS-1:0] wanted_average,
    output logic                     divide_fault,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [DATA_BITS-1:0]     pwdata,
    output logic [DATA_BITS-1:0]     prdata,
    output logic                     pready
);

    // configuration
    logic                     enable_reg;
    logic [COORD_BITS-1:0]    left_reg;
    logic [COORD_BITS-1:0]    top_reg;
    logic [ROI_BITS-1:0]      cols_reg;
    logic [ROI_BITS-1:0]      rows_reg;
    logic [TGT_BITS-1:0]      target_reg;
    logic [EXPOSURE_BITS-1:0] floor_reg;
    logic [EXPOSURE_BITS-1:0] ceil_reg;

    // frame state
    logic [SUM_BITS-1:0]      frame_sum_reg, frame_sum_next;
    logic [SUM_BITS-1:0]      region_sum_reg, region_sum_next;
    logic [COUNT_BITS-1:0]    count_reg, count_next;
    logic [EXPOSURE_BITS-1:0] exposure_reg;
    logic [1:0]               phase_reg;

    // sequencer
    logic [STEP_BITS-1:0]     step_reg, step_next;
    ucode_t                   uc;

    // divider and datapath
    logic [NUM_BITS-1:0]      num_reg;
    logic [DEN_BITS-1:0]      den_reg;
    logic [DEN_BITS-1:0]      rem_reg;
    logic [CNT_BITS-1:0]      cnt_reg;
    logic [DEN_BITS:0]        trial;
    logic                     trial_ge;
    logic [DEN_BITS:0]        trial_sub;
    logic [NUM_BITS-1:0]      src_num;
    logic [DEN_BITS-1:0]      src_den;

    logic [AREA_BITS-1:0]     area_reg;
    logic [PIXEL_BITS-1:0]    fa_reg;
    logic [PIXEL_BITS-1:0]    ra_calc;
    logic signed [WANT_BITS-1:0] want_reg, want_calc;
    logic [PROD_BITS-1:0]     prod_reg;

    logic                     fault;
    logic [EXPOSURE_BITS-1:0] ceil_eff;
    logic [NUM_BITS-1:0]      q_min;
    logic [EXPOSURE_BITS-1:0] q_final;

    // output register
    logic                     out_valid_reg;
    logic [1:0]               phase_out_reg;
    logic [EXPOSURE_BITS-1:0] exp_out_reg;
    logic [PIXEL_BITS-1:0]    fa_out_reg;
    logic [PIXEL_BITS-1:0]    ra_out_reg;
    logic signed [WANT_BITS-1:0] want_out_reg;
    logic                     fault_out_reg;

    logic                     in_accept;
    logic                     frame_done;
    logic                     pattern_end;
    logic                     update_start;
    logic                     clear_frame;
    logic                     in_region;
    logic [ROI_BITS:0]        col_lim;
    logic [ROI_BITS:0]        row_lim;
    logic                     cfg_write;
    reg_idx_t                 cfg_idx;
    logic [EXPOSURE_BITS-1:0] new_floor;
    logic [EXPOSURE_BITS-1:0] new_ceil;
    logic [SUM_BITS:0]        fsum_add;
    logic [SUM_BITS:0]        rsum_add;

    assign uc = ucode_rom(step_reg);

    assign in_stall  = (step_reg != STEP_IDLE) || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    assign frame_done   = in_accept && enable_reg && frame_end;
    assign pattern_end  = frame_done && (phase_reg < PHASE_UPDATE);
    assign update_start = frame_done && (phase_reg >= PHASE_UPDATE);
    assign clear_frame  = (in_accept && frame_end && !enable_reg) || pattern_end ||
                          (uc.capture == CAP_DONE);

    assign col_lim   = (ROI_BITS+1)'(left_reg) + (ROI_BITS+1)'(cols_reg);
    assign row_lim   = (ROI_BITS+1)'(top_reg) + (ROI_BITS+1)'(rows_reg);
    assign in_region = (column >= left_reg) && ((ROI_BITS+1)'(column) < col_lim) &&
                       (row >= top_reg) && ((ROI_BITS+1)'(row) < row_lim);

    assign fsum_add = (SUM_BITS+1)'(frame_sum_reg) + (SUM_BITS+1)'(pixel);
    assign rsum_add = (SUM_BITS+1)'(region_sum_reg) + (SUM_BITS+1)'(pixel);

    always_comb
    begin
        frame_sum_next  = frame_sum_reg;
        region_sum_next = region_sum_reg;
        count_next      = count_reg;
        if (clear_frame)
        begin
            frame_sum_next  = '0;
            region_sum_next = '0;
            count_next      = '0;
        end
        else if (in_accept && enable_reg)
        begin
            frame_sum_next = fsum_add[SUM_BITS] ? '1 : fsum_add[SUM_BITS-1:0];
            if (in_region)
                region_sum_next = rsum_add[SUM_BITS] ? '1 : rsum_add[SUM_BITS-1:0];
            if (count_reg != '1)
                count_next = count_reg + 1'b1;
        end
    end

    always_comb
    begin
        if (step_reg == STEP_IDLE)
            step_next = update_start ? STEP_AREA : STEP_IDLE;
        else if (uc.last)
            step_next = STEP_IDLE;
        else if (uc.div_wait && cnt_reg != '0)
            step_next = step_reg;
        else
            step_next = step_reg + 1'b1;
    end

    // divider operands
    always_comb
    begin
        case (uc.div_src)
            SRC_FRAME:
            begin
                src_num = NUM_BITS'(frame_sum_reg);
                src_den = DEN_BITS'(count_reg);
            end
            SRC_REGION:
            begin
                src_num = NUM_BITS'(region_sum_reg);
                src_den = DEN_BITS'(area_reg);
            end
            SRC_EXPOSURE:
            begin
                src_num = NUM_BITS'(prod_reg);
                src_den = DEN_BITS'(fa_reg);
            end
            default:
            begin
                src_num = '0;
                src_den = '0;
            end
        endcase
    end

    assign trial     = {rem_reg, num_reg[NUM_BITS-1]};
    assign trial_ge  = trial >= {1'b0, den_reg};
    assign trial_sub = trial - {1'b0, den_reg};

    // quotient sits in num_reg once the count runs out
    assign ra_calc   = (area_reg == '0) ? '0 :
                       (|num_reg[NUM_BITS-1:PIXEL_BITS]) ? '1 : num_reg[PIXEL_BITS-1:0];
    assign want_calc = $signed(WANT_BITS'(fa_reg)) + $signed(WANT_BITS'(target_reg)) -
                       $signed(WANT_BITS'(ra_calc));

    assign fault    = (count_reg == '0) || (area_reg == '0) || (fa_reg == '0);
    assign ceil_eff = (ceil_reg == '0) ? EXPOSURE_BITS'(1) : ceil_reg;
    assign q_min    = (num_reg == '0) ? NUM_BITS'(1) : num_reg;
    assign q_final  = (q_min > NUM_BITS'(ceil_eff)) ? ceil_eff : q_min[EXPOSURE_BITS-1:0];

    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[4:2]);
    assign new_floor = (cfg_idx == REG_FLOOR) ? pwdata[EXPOSURE_BITS-1:0] : floor_reg;
    assign new_ceil  = (cfg_idx == REG_CEIL) ? pwdata[EXPOSURE_BITS-1:0] : ceil_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            left_reg       <= '0;
            top_reg        <= '0;
            cols_reg       <= '0;
            rows_reg       <= '0;
            target_reg     <= TARGET_RESET;
            floor_reg      <= FLOOR_RESET;
            ceil_reg       <= CEIL_RESET;
            frame_sum_reg  <= '0;
            region_sum_reg <= '0;
            count_reg      <= '0;
            exposure_reg   <= start_exposure(FLOOR_RESET, CEIL_RESET);
            phase_reg      <= '0;
            step_reg       <= STEP_IDLE;
            cnt_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            frame_sum_reg  <= frame_sum_next;
            region_sum_reg <= region_sum_next;
            count_reg      <= count_next;
            step_reg       <= step_next;

            if (frame_done && phase_reg != PHASE_LAST)
                phase_reg <= phase_reg + 1'b1;

            if (uc.div_load)
                cnt_reg <= CNT_BITS'(NUM_BITS);
            else if (cnt_reg != '0)
                cnt_reg <= cnt_reg - 1'b1;

            if (uc.capture == CAP_DONE && !fault)
                exposure_reg <= q_final;

            if (cfg_write)
            begin
                case (cfg_idx)
                    REG_ENABLE: enable_reg <= pwdata[0];
                    REG_LEFT:   left_reg   <= pwdata[COORD_BITS-1:0];
                    REG_TOP:    top_reg    <= pwdata[COORD_BITS-1:0];
                    REG_COLS:   cols_reg   <= pwdata[ROI_BITS-1:0];
                    REG_ROWS:   rows_reg   <= pwdata[ROI_BITS-1:0];
                    REG_TARGET: target_reg <= pwdata[TGT_BITS-1:0];
                    REG_FLOOR:  floor_reg  <= new_floor;
                    REG_CEIL:   ceil_reg   <= new_ceil;
                    default: ;
                endcase
                if ((cfg_idx == REG_FLOOR || cfg_idx == REG_CEIL) &&
                    phase_reg < PHASE_UPDATE)
                    exposure_reg <= start_exposure(new_floor, new_ceil);
            end

            if (pattern_end || uc.capture == CAP_DONE)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (uc.div_load)
        begin
            num_reg <= src_num;
            den_reg <= src_den;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= trial_ge ? trial_sub[DEN_BITS-1:0] : trial[DEN_BITS-1:0];
            num_reg <= {num_reg[NUM_BITS-2:0], trial_ge};
        end

        case (uc.capture)
            CAP_AREA: area_reg <= AREA_BITS'(cols_reg) * AREA_BITS'(rows_reg);
            CAP_FA:   fa_reg   <= (count_reg == '0) ? '0 : num_reg[PIXEL_BITS-1:0];
            CAP_RA:
            begin
                want_reg   <= want_calc;
                ra_out_reg <= ra_calc;
            end
            CAP_PROD:
            begin
                if (want_reg > 0)
                    prod_reg <= PROD_BITS'(want_reg[WANT_BITS-2:0]) *
                                PROD_BITS'(exposure_reg);
                else
                    prod_reg <= '0;
            end
            default: ;
        endcase

        if (pattern_end)
        begin
            phase_out_reg <= phase_reg;
            exp_out_reg   <= exposure_reg;
            fa_out_reg    <= '0;
            ra_out_reg    <= '0;
            want_out_reg  <= '0;
            fault_out_reg <= 1'b0;
        end
        else if (uc.capture == CAP_DONE)
        begin
            phase_out_reg <= PHASE_UPDATE;
            exp_out_reg   <= fault ? exposure_reg : q_final;
            fa_out_reg    <= fa_reg;
            want_out_reg  <= want_reg;
            fault_out_reg <= fault;
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_ENABLE: prdata = DATA_BITS'(enable_reg);
            REG_LEFT:   prdata = DATA_BITS'(left_reg);
            REG_TOP:    prdata = DATA_BITS'(top_reg);
            REG_COLS:   prdata = DATA_BITS'(cols_reg);
            REG_ROWS:   prdata = DATA_BITS'(rows_reg);
            REG_TARGET: prdata = DATA_BITS'(target_reg);
            REG_FLOOR:  prdata = DATA_BITS'(floor_reg);
            REG_CEIL:   prdata = DATA_BITS'(ceil_reg);
            default:    prdata = '0;
        endcase
    end

    assign pready         = 1'b1;
    assign out_valid      = out_valid_reg;
    assign phase          = phase_out_reg;
    assign new_exposure   = exp_out_reg;
    assign frame_average  = fa_out_reg;
    assign roi_average    = ra_out_reg;
    assign wanted_average = want_out_reg;
    assign divide_fault   = fault_out_reg;

endmodule

[hdl/roiae_checker.sv]
module roiae_checker
    import roiae_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [1:0]               phase,
    input logic [EXPOSURE_BITS-1:0] new_exposure,
    input logic [PIXEL_BITS-1:0]    frame_average,
    input logic [PIXEL_BITS-1:0]    roi_average,
    input logic signed [WANT_BITS-1:0] wanted_average,
    input logic                     divide_fault
);

    // stalled word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_exposure) && $stable(phase))
        else $error("stalled output word changed");

    // pattern frames carry no statistics
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase != PHASE_UPDATE |-> !divide_fault && frame_average == '0 &&
            roi_average == '0 && wanted_average == '0)
        else $error("pattern word carries statistics");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == PHASE_UPDATE && !divide_fault |-> new_exposure != '0)
        else $error("updated exposure is zero");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase == PHASE_UPDATE && !divide_fault |-> frame_average != '0)
        else $error("update without fault has zero frame average");

endmodule

bind roi_auto_exposure_update roiae_checker u_roiae_checker (.*);
